FILE: src/bcsle_pkg.sv
// shared character codes, widths and classification for the c string literal escaper
package bcsle_pkg;

    localparam int CHAR_W    = 7;
    localparam int BYTE_W    = 8;
    localparam int LIMIT_W   = 7;
    localparam int MAX_CHARS = 9;
    localparam int CNT_W     = 4;
    localparam int SEQ_W     = CHAR_W * MAX_CHARS;

    typedef logic [CHAR_W-1:0] t_char;

    localparam t_char CH_QUOTE  = 7'h22;
    localparam t_char CH_NL     = 7'h0a;
    localparam t_char CH_SEMI   = 7'h3b;
    localparam t_char CH_BSLASH = 7'h5c;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd77;
    localparam logic [BYTE_W-1:0]  SHORT_OCT_MAX = 8'o077;

    // action codes
    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    // single letter of a named backslash escape, zero if none
    function automatic t_char esc_letter(input logic [BYTE_W-1:0] ch);
        t_char e;
        case (ch)
            8'h07: e = 7'h61;
            8'h08: e = 7'h62;
            8'h09: e = 7'h74;
            8'h0a: e = 7'h6e;
            8'h0b: e = 7'h76;
            8'h0c: e = 7'h66;
            8'h0d: e = 7'h72;
            8'h22: e = 7'h22;
            8'h27: e = 7'h27;
            8'h3f: e = 7'h3f;
            8'h5c: e = 7'h5c;
            default: e = '0;
        endcase
        return e;
    endfunction

    // digits, letters and the fixed punctuation set
    function automatic logic is_plain(input logic [BYTE_W-1:0] ch);
        logic p;
        p = 1'b0;
        if (ch >= 8'h30 && ch <= 8'h39) p = 1'b1;
        if (ch >= 8'h61 && ch <= 8'h7a) p = 1'b1;
        if (ch >= 8'h41 && ch <= 8'h5a) p = 1'b1;
        case (ch)
            8'h20, 8'h3b, 8'h2c, 8'h3a, 8'h2e, 8'h5e, 8'h2d, 8'h2b,
            8'h3d, 8'h2a, 8'h2f, 8'h25, 8'h7c, 8'h26, 8'h5b, 8'h5d,
            8'h28, 8'h29, 8'h7b, 8'h7d, 8'h3c, 8'h3e, 8'h23, 8'h5f: p = 1'b1;
            default: ;
        endcase
        return p;
    endfunction

endpackage

FILE: src/byte_to_c_string_literal_escaper.sv
// top level: byte stream to c string literal character stream
//
// Each accepted item is expanded combinationally into its full character
// sequence (1 to 8 characters: line open quote, empty-literal break, the
// byte or its escape, line close), which is held in a sequence buffer and
// shifted out one character per cycle while the receiver is ready, through
// a registered output stage. The next item is taken in the same cycle that
// the last character of the previous one moves to the output register, so
// the output runs without gaps while both sides keep up.
// line_limit is written through the cfg channel, which is always ready and
// is meant to be used only while no item is in flight.
module byte_to_c_string_literal_escaper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic        s_axis_tuser,   // [0] action
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic        m_axis_tlast,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data      // [6:0] line_limit
);
    import bcsle_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    logic [LIMIT_W-1:0] r_col,  n_col;
    logic               r_pso,  n_pso;
    logic [SEQ_W-1:0]   r_seq,  n_seq;
    logic [CNT_W-1:0]   r_cnt,  n_cnt;
    logic               r_ovalid;
    t_char              r_ochar;
    logic               r_olast;

    logic accept;
    logic move;

    assign move          = (r_cnt != '0) && (!r_ovalid || m_axis_tready);
    assign s_axis_tready = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && move);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // expansion of one item
    logic [2*CHAR_W-1:0] pre_bits, suf_bits;
    logic [4*CHAR_W-1:0] body_bits;
    logic [1:0]          plen, slen;
    logic [2:0]          blen;
    logic [LIMIT_W:0]    total;
    logic                open_line, pso_eff, short_oct, brk, close_line;
    t_char               esc;
    logic [BYTE_W-1:0]   ch;

    assign ch = s_axis_tdata;

    always_comb begin
        pre_bits   = '0;
        suf_bits   = '0;
        body_bits  = '0;
        plen       = '0;
        slen       = '0;
        blen       = '0;
        total      = '0;
        open_line  = (r_col == '0);
        pso_eff    = r_pso && !open_line;
        short_oct  = 1'b0;
        brk        = 1'b0;
        close_line = 1'b0;
        esc        = esc_letter(ch);
        n_col      = r_col;
        n_pso      = r_pso;
        if (s_axis_tuser == ACT_FINISH) begin
            if (!open_line) begin
                pre_bits = {CH_NL, CH_QUOTE};
                plen     = 2'd2;
            end
            body_bits = {14'b0, CH_NL, CH_SEMI};
            blen      = 3'd2;
            n_col     = '0;
            n_pso     = 1'b0;
        end else begin
            if (esc != '0) begin
                body_bits = {14'b0, esc, CH_BSLASH};
                blen      = 3'd2;
            end else if (is_plain(ch)) begin
                body_bits = {21'b0, ch[CHAR_W-1:0]};
                blen      = 3'd1;
            end else if (ch >= 8'o100) begin
                body_bits = {4'b0110, ch[2:0], 4'b0110, ch[5:3],
                             4'b0110, {1'b0, ch[7:6]}, CH_BSLASH};
                blen      = 3'd4;
            end else if (ch >= 8'o010) begin
                body_bits = {7'b0, 4'b0110, ch[2:0], 4'b0110, ch[5:3], CH_BSLASH};
                blen      = 3'd3;
            end else begin
                body_bits = {14'b0, 4'b0110, ch[2:0], CH_BSLASH};
                blen      = 3'd2;
            end
            short_oct = (esc == '0) && !is_plain(ch) && (ch <= SHORT_OCT_MAX);
            // a plain digit 0..7 right after a short octal escape needs a break
            brk = pso_eff && (ch >= 8'h30) && (ch <= 8'h37);
            if (open_line) begin
                pre_bits = {7'b0, CH_QUOTE};
                plen     = 2'd1;
            end else if (brk) begin
                pre_bits = {CH_QUOTE, CH_QUOTE};
                plen     = 2'd2;
            end
            total = {1'b0, r_col} + {5'b0, blen} + (brk ? (LIMIT_W+1)'(2) : '0);
            close_line = (total >= {1'b0, r_limit});
            if (close_line) begin
                suf_bits = {CH_NL, CH_QUOTE};
                slen     = 2'd2;
            end
            n_col = close_line ? '0 : total[LIMIT_W-1:0];
            n_pso = short_oct;
        end
        n_seq = SEQ_W'(pre_bits)
              | (SEQ_W'(body_bits) << (CHAR_W * plen))
              | (SEQ_W'(suf_bits) << (CHAR_W * (plen + blen)));
        n_cnt = CNT_W'(plen) + CNT_W'(blen) + CNT_W'(slen);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LIMIT_RESET;
            r_col    <= '0;
            r_pso    <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
            if (accept) begin
                r_col <= n_col;
                r_pso <= n_pso;
                r_cnt <= n_cnt;
            end else if (move) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (move) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload: sequence buffer shifts one character toward the output
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_seq <= n_seq;
        end else if (move) begin
            r_seq <= r_seq >> CHAR_W;
        end
        if (move) begin
            r_ochar <= r_seq[CHAR_W-1:0];
            r_olast <= (r_cnt == CNT_W'(1));
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_ochar};
    assign m_axis_tlast  = r_olast;

endmodule

FILE: src/bcsle_checker.sv
// port-level checks for the c string literal escaper, bound to the top level
module bcsle_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);
    import bcsle_pkg::*;

    // a stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("stalled output item changed");

    // nothing comes out right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // an accepted item must be followed by a valid output character
    a_item_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
        else $error("accepted item produced no output");

    // characters are 7-bit ascii
    a_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7] == 1'b0))
        else $error("output character outside ascii");

endmodule

bind byte_to_c_string_literal_escaper bcsle_checker u_bcsle_checker (.*);

FILE: tb/sv/byte_to_c_string_literal_escaper_tb.sv
// testbench for the c string literal escaper: directed table, then random bytes per line limit
module byte_to_c_string_literal_escaper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bcsle_pkg::*;

    localparam int CLK_PERIOD      = 4;
    localparam int RST_CYCLES      = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int DRAIN_CYCLES    = 16;
    localparam int TIMEOUT_NS      = 2_000_000;

    typedef struct {
        t_char ch;
        logic  last;
    } t_lit_char;

    typedef struct {
        bit          is_cfg;
        logic        act;
        logic [7:0]  val;
        string       want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] byte_value
    logic        s_axis_tuser = 1'b0; // [0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [6:0] out_char, [7] zero
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data = '0;     // [6:0] line_limit

    // predictor state
    logic [LIMIT_W-1:0] pred_limit = LIMIT_RESET;
    int unsigned        pred_col = 0;
    bit                 pred_short = 1'b0;
    t_char              step_chars[$];

    t_lit_char   pending_chars[$];
    t_stim_row   dir_rows[$];
    int          mismatches = 0;
    int          burst_left = 0;
    bit          hold_req = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    byte_to_c_string_literal_escaper u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // characters one item produces, left in step_chars; advances the line state
    function automatic void predict_step(logic act, logic [7:0] b);
        logic [7:0]  seq[$];
        logic [7:0]  esc;
        logic [7:0]  pc;
        bit          plain;
        bit          short_now;
        int unsigned cnt;
        string       punct = " ;,:.^-+=*/%|&[](){}<>#_";
        step_chars.delete();
        if (act == ACT_FINISH) begin
            if (pred_col != 0) begin
                step_chars.push_back(CH_QUOTE);
                step_chars.push_back(CH_NL);
            end
            step_chars.push_back(CH_SEMI);
            step_chars.push_back(CH_NL);
            pred_col = 0;
            pred_short = 1'b0;
            return;
        end
        if (pred_col == 0) begin
            step_chars.push_back(CH_QUOTE);
            pred_short = 1'b0;
        end
        case (b)
            8'h07: esc = "a";
            8'h08: esc = "b";
            8'h09: esc = "t";
            8'h0a: esc = "n";
            8'h0b: esc = "v";
            8'h0c: esc = "f";
            8'h0d: esc = "r";
            8'h22: esc = "\"";
            8'h27: esc = "'";
            8'h3f: esc = "?";
            8'h5c: esc = "\\";
            default: esc = 8'h00;
        endcase
        plain = (b >= "0" && b <= "9") || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
        for (int i = 0; i < punct.len(); i++) begin
            pc = punct[i];
            if (pc == b) plain = 1'b1;
        end
        short_now = 1'b0;
        if (esc != 8'h00) begin
            seq.push_back({1'b0, CH_BSLASH});
            seq.push_back(esc);
        end else if (plain) begin
            seq.push_back(b);
        end else begin
            // octal escape without leading zeros
            seq.push_back({1'b0, CH_BSLASH});
            short_now = (b <= SHORT_OCT_MAX);
            if (b >= 8'o100) seq.push_back("0" + b[7:6]);
            if (b >= 8'o10) seq.push_back("0" + b[5:3]);
            seq.push_back("0" + b[2:0]);
        end
        cnt = pred_col + seq.size();
        // a digit 0..7 right after a short octal escape needs an empty-literal break
        if (pred_short && !short_now && seq[0] >= "0" && seq[0] <= "7") begin
            step_chars.push_back(CH_QUOTE);
            step_chars.push_back(CH_QUOTE);
            cnt += 2;
        end
        pred_short = short_now;
        foreach (seq[i]) step_chars.push_back(seq[i][6:0]);
        if (cnt >= pred_limit) begin
            step_chars.push_back(CH_QUOTE);
            step_chars.push_back(CH_NL);
            cnt = 0;
        end
        pred_col = cnt % 128;
    endfunction

    // typed characters if given, else the predicted ones
    function automatic void queue_chars(string want);
        t_lit_char  c;
        logic [7:0] wc;
        int         n;
        n = (want.len() == 0) ? step_chars.size() : want.len();
        for (int i = 0; i < n; i++) begin
            if (want.len() == 0) begin
                c.ch = step_chars[i];
            end else begin
                wc = want[i];
                c.ch = wc[6:0];
            end
            c.last = (i == n - 1);
            pending_chars.push_back(c);
        end
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] esc_set[11] = '{8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c,
                                    8'h0d, 8'h22, 8'h27, 8'h3f, 8'h5c};
        case ($urandom_range(0, 9))
            0, 1: return 8'($urandom_range(0, 63));
            2, 3: return 8'($urandom_range(8'h30, 8'h39));
            4: return esc_set[$urandom_range(0, 10)];
            5: return 8'($urandom_range(128, 255));
            6, 7: return 8'($urandom_range(32, 126));
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic void add_row(bit is_cfg, logic act, logic [7:0] val, string want);
        t_stim_row r;
        r.is_cfg = is_cfg;
        r.act = act;
        r.val = val;
        r.want = want;
        dir_rows.push_back(r);
    endfunction

    task automatic send_item(logic act, logic [7:0] b, string want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_step(act, b);
        queue_chars(want);
        burst_left--;
    endtask

    // only while nothing is in flight
    task automatic write_limit(logic [6:0] v);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pred_limit = v;
    endtask

    // receiver stall pattern, with one long hold-off on request
    initial begin : rx_pattern
        int run_len;
        int stall_len;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            run_len = $urandom_range(1, 24);
            repeat (run_len) @(posedge i_clk);
            stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (stall_len != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_lit_char w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected char: expected none, got %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                mismatches++;
            end else begin
                w = pending_chars.pop_front();
                if (m_axis_tdata !== {1'b0, w.ch}) begin
                    $display("%0t: out_char mismatch: expected %h, got %h",
                             $time, {1'b0, w.ch}, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tlast !== w.last) begin
                    $display("%0t: last mismatch: expected %b, got %b",
                             $time, w.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial begin : run_limit
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    initial begin : stim_main
        t_stim_row  r;
        logic       act;
        logic [6:0] limits[4];

        // reset limit, line opens on the first byte
        add_row(0, ACT_ENCODE, 8'h41, "\"A");
        add_row(0, ACT_ENCODE, 8'h00, "\\0");
        add_row(0, ACT_ENCODE, 8'h35, "");      // break after a short escape
        add_row(0, ACT_ENCODE, 8'hff, "\\377");
        add_row(0, ACT_ENCODE, 8'h07, "");
        add_row(0, ACT_ENCODE, 8'h08, "");
        add_row(0, ACT_ENCODE, 8'h09, "");
        add_row(0, ACT_ENCODE, 8'h0a, "");
        add_row(0, ACT_ENCODE, 8'h0b, "");
        add_row(0, ACT_ENCODE, 8'h0c, "");
        add_row(0, ACT_ENCODE, 8'h0d, "");
        add_row(0, ACT_ENCODE, 8'h22, "");
        add_row(0, ACT_ENCODE, 8'h27, "");
        add_row(0, ACT_ENCODE, 8'h3f, "");
        add_row(0, ACT_ENCODE, 8'h5c, "");
        add_row(0, ACT_ENCODE, 8'h1f, "");
        add_row(0, ACT_ENCODE, 8'h37, "");
        add_row(0, ACT_ENCODE, 8'h01, "");
        add_row(0, ACT_ENCODE, 8'h38, "");      // 8 is no octal digit, no break
        add_row(0, ACT_ENCODE, 8'h40, "");
        add_row(0, ACT_ENCODE, 8'h30, "");
        add_row(0, ACT_ENCODE, 8'h80, "");
        add_row(0, ACT_FINISH, 8'h00, "\"\n;\n");
        add_row(0, ACT_FINISH, 8'hff, ";\n");
        // zero limit closes the line after every byte
        add_row(1, ACT_ENCODE, 8'h00, "");
        add_row(0, ACT_ENCODE, 8'h7e, "\"\\176\"\n");
        add_row(0, ACT_ENCODE, 8'h20, "");
        add_row(0, ACT_FINISH, 8'h00, ";\n");

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            r = dir_rows[k];
            if (r.is_cfg) write_limit(r.val[6:0]);
            else send_item(r.act, r.val, r.want);
        end

        limits = '{7'd120, 7'd1, 7'($urandom_range(2, 119)), LIMIT_RESET};
        foreach (limits[p]) begin
            write_limit(limits[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 0 && n == 60) hold_req = 1'b1;
                act = ($urandom_range(0, 24) == 0) ? ACT_FINISH : ACT_ENCODE;
                send_item(act, pick_byte(), "");
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: files.f
src/bcsle_pkg.sv
src/byte_to_c_string_literal_escaper.sv
src/bcsle_checker.sv
tb/sv/byte_to_c_string_literal_escaper_tb.sv
